@@ hdl/stnf_pkg.sv @@
// Shared types, codes and constants for the scale-table note-to-frequency block.
// No dependencies; every other file imports this package.
package stnf_pkg;

    localparam int WORD_W    = 32;
    localparam int DIV_CNT_W = 5;   // counts WORD_W quotient bits
    localparam int NOTE_W    = 7;
    localparam int NOTE_CNT_W = 3;  // counts NOTE_W dividend bits
    localparam int ET_COUNT  = 12;

    // Input operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_ANCHOR = 2'd1;
    localparam logic [1:0] REG_SIZE   = 2'd2;
    localparam logic [1:0] REG_PERIOD = 2'd3;

    localparam logic [31:0] BASE_RESET   = 32'd28835840;
    localparam logic [6:0]  ANCHOR_RESET = 7'd69;
    localparam logic [7:0]  SIZE_RESET   = 8'd12;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2,
        ST_WRITE = 2'd3
    } status_t;

    // Scale degree split of one query
    typedef struct packed {
        logic       neg;
        logic [6:0] steps;
        logic [7:0] degree;
    } deg_res_t;

    // Power engine command
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] ratio;
        logic [31:0] period;
        logic [6:0]  steps;
        logic        neg;
    } pow_cmd_t;

    typedef struct packed {
        logic [31:0] freq;
        logic        sat;
    } pow_res_t;

    // 2^(k/12) with 30 fractional bits, rounded to nearest
    function automatic logic [31:0] et_ratio30(input logic [3:0] k);
        logic [31:0] r;
        unique case (k)
            4'd0:    r = 32'd1073741824;
            4'd1:    r = 32'd1137589835;
            4'd2:    r = 32'd1205234447;
            4'd3:    r = 32'd1276901417;
            4'd4:    r = 32'd1352829926;
            4'd5:    r = 32'd1433273380;
            4'd6:    r = 32'd1518500250;
            4'd7:    r = 32'd1608794974;
            4'd8:    r = 32'd1704458901;
            4'd9:    r = 32'd1805811301;
            4'd10:   r = 32'd1913190429;
            4'd11:   r = 32'd2026954652;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/stnf_ratio_mem.sv @@
// Ratio table: one-write one-read synchronous memory with per-entry valid bits.
// Entries never written read as the equal-temperament reset table. Uses stnf_pkg.
module stnf_ratio_mem
    import stnf_pkg::*;
#(
    parameter int DEPTH     = 128,
    parameter int FRAC_BITS = 28
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [31:0]              wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [31:0]              rd_data
);

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [31:0]      raw_reg;
    logic [31:0]      init_reg;
    logic             hit_reg;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            raw_reg <= mem[rd_addr];
            hit_reg <= vld_reg[rd_addr];
            if (32'(rd_addr) < ET_COUNT) begin
                init_reg <= et_ratio30(4'(rd_addr)) >> (30 - FRAC_BITS);
            end else begin
                init_reg <= '0;
            end
        end
    end

    assign rd_data = hit_reg ? raw_reg : init_reg;

endmodule

@@ hdl/stnf_deg_div.sv @@
// Degree divider: splits note minus anchor into scale degree and period steps,
// one quotient bit per cycle (restoring division). Uses stnf_pkg.
module stnf_deg_div
    import stnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [6:0]  note,
    input  logic [6:0]  anchor,
    input  logic [7:0]  size,
    output logic        done,
    output deg_res_t    res
);

    logic [7:0]            diff;
    logic [7:0]            diff_neg;
    logic [6:0]            mag;
    logic [8:0]            trial;
    logic                  ge;
    logic                  wrap;

    logic                  busy_reg;
    logic                  done_reg;
    logic [NOTE_CNT_W-1:0] cnt_reg;
    logic [6:0]            mag_reg;
    logic [7:0]            rem_reg;
    logic [6:0]            quo_reg;
    logic [7:0]            size_reg;
    logic                  neg_reg;

    assign diff     = {1'b0, note} - {1'b0, anchor};
    assign diff_neg = 8'd0 - diff;
    assign mag      = diff[7] ? diff_neg[6:0] : diff[6:0];

    assign trial = {rem_reg, mag_reg[6]};
    assign ge    = trial >= {1'b0, size_reg};

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == NOTE_CNT_W'(NOTE_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            mag_reg  <= mag;
            rem_reg  <= '0;
            quo_reg  <= '0;
            size_reg <= size;
            neg_reg  <= diff[7];
        end else if (busy_reg) begin
            mag_reg <= {mag_reg[5:0], 1'b0};
            rem_reg <= ge ? 8'(trial - {1'b0, size_reg}) : trial[7:0];
            quo_reg <= {quo_reg[5:0], ge};
        end
    end

    // Floor division: a negative offset with a remainder wraps one period down
    assign wrap       = neg_reg && (rem_reg != 8'd0);
    assign res.neg    = neg_reg;
    assign res.degree = wrap ? (size_reg - rem_reg) : rem_reg;
    assign res.steps  = wrap ? (quo_reg + 7'd1) : quo_reg;
    assign done       = done_reg;

endmodule

@@ hdl/stnf_pow_unit.sv @@
// Power engine: base times ratio, then one period multiply or divide per step,
// with saturation. Shared 32x32 multiplier and a bit-serial divider. Uses stnf_pkg.
module stnf_pow_unit
    import stnf_pkg::*;
#(
    parameter int FRAC_BITS = 28
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  pow_cmd_t cmd,
    output logic     done,
    output pow_res_t res
);

    typedef enum logic [5:0] {
        P_IDLE = 6'b000001,
        P_MUL  = 6'b000010,
        P_CHK  = 6'b000100,
        P_STEP = 6'b001000,
        P_DIV  = 6'b010000,
        P_DONE = 6'b100000
    } pstate_t;

    pstate_t              state_reg, state_next;
    logic [6:0]           cnt_reg;
    logic [DIV_CNT_W-1:0] bit_reg;
    logic                 sat_reg;
    logic                 neg_reg;

    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [63:0] prod_reg;
    logic [31:0] acc_reg;
    logic [31:0] rem_reg;
    logic [31:0] num_reg;
    logic [31:0] period_reg;

    logic [63:0] shifted;
    logic        over;
    logic [31:0] hi;
    logic        div_ovf;
    logic [32:0] trial;
    logic [32:0] trial_sub;
    logic        ge;

    assign shifted   = prod_reg >> FRAC_BITS;
    assign over      = |shifted[63:32];
    // Upper word of acc << FRAC_BITS; quotient overflows when it reaches the divisor
    assign hi        = acc_reg >> (WORD_W - FRAC_BITS);
    assign div_ovf   = hi >= period_reg;
    assign trial     = {rem_reg, num_reg[31]};
    assign trial_sub = trial - {1'b0, period_reg};
    assign ge        = trial >= {1'b0, period_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            P_IDLE: if (start) state_next = P_MUL;
            P_MUL:  state_next = P_CHK;
            P_CHK:  state_next = over ? P_DONE : P_STEP;
            P_STEP: begin
                if (cnt_reg == 7'd0) begin
                    state_next = P_DONE;
                end else if (!neg_reg) begin
                    state_next = P_MUL;
                end else begin
                    state_next = div_ovf ? P_DONE : P_DIV;
                end
            end
            P_DIV:  if (bit_reg == DIV_CNT_W'(WORD_W - 1)) state_next = P_STEP;
            P_DONE: state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= P_IDLE;
            cnt_reg   <= '0;
            bit_reg   <= '0;
            sat_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                P_IDLE: if (start) begin
                    cnt_reg <= cmd.steps;
                    neg_reg <= cmd.neg;
                    sat_reg <= 1'b0;
                end
                P_CHK:  if (over) sat_reg <= 1'b1;
                P_STEP: if (cnt_reg != 7'd0) begin
                    cnt_reg <= cnt_reg - 7'd1;
                    bit_reg <= '0;
                    if (neg_reg && div_ovf) sat_reg <= 1'b1;
                end
                P_DIV:  bit_reg <= bit_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        unique case (state_reg)
            P_IDLE: if (start) begin
                a_reg      <= cmd.base;
                b_reg      <= cmd.ratio;
                period_reg <= cmd.period;
            end
            P_MUL:  prod_reg <= 64'(a_reg) * 64'(b_reg);
            P_CHK:  acc_reg  <= shifted[31:0];
            P_STEP: begin
                a_reg   <= acc_reg;
                b_reg   <= period_reg;
                rem_reg <= hi;
                num_reg <= acc_reg << FRAC_BITS;
            end
            P_DIV: begin
                rem_reg <= ge ? trial_sub[31:0] : trial[31:0];
                num_reg <= {num_reg[30:0], ge};
                if (bit_reg == DIV_CNT_W'(WORD_W - 1)) begin
                    acc_reg <= {num_reg[30:0], ge};
                end
            end
            default: ;
        endcase
    end

    assign done     = (state_reg == P_DONE);
    assign res.sat  = sat_reg;
    assign res.freq = sat_reg ? '1 : acc_reg;

endmodule

@@ hdl/scale_table_note_to_frequency_top.sv @@
// Scale-table note-to-frequency converter, top level. Uses stnf_pkg and the units
// stnf_ratio_mem, stnf_deg_div and stnf_pow_unit.
// A table write or an out-of-range note goes from T_IDLE straight to T_DONE. A query
// passes through T_DIV, T_READ, T_POW and T_DONE, with one multiply per upward period
// step or one bit-serial divide per downward step; at most 127 steps are applied.
// Throughput: one transaction at a time; the next is taken once out_freq_reg loads.
// Reset: synchronous, active low; restores the config registers and the 12-TET table.
module scale_table_note_to_frequency_top
    import stnf_pkg::*;
#(
    parameter int TABLE_DEPTH     = 128,
    parameter int RATIO_FRAC_BITS = 28
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] entry_index, [38:7] ratio_value, [46:39] note_number, [47] zero
    input  logic [47:0] s_tdata,
    // [0] operation
    input  logic [0:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] frequency
    output logic [31:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Only 7-bit indexes can be written, so entries above 127 always read zero
    localparam int MEM_DEPTH = (TABLE_DEPTH < 128) ? TABLE_DEPTH : 128;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam logic [31:0] PERIOD_RESET = 32'(64'd1 << (RATIO_FRAC_BITS + 1));

    typedef enum logic [4:0] {
        T_IDLE = 5'b00001,
        T_DIV  = 5'b00010,
        T_READ = 5'b00100,
        T_POW  = 5'b01000,
        T_DONE = 5'b10000
    } tstate_t;

    tstate_t     state_reg, state_next;

    logic [31:0] base_reg;
    logic [6:0]  anchor_reg;
    logic [7:0]  size_reg;
    logic [31:0] period_reg;

    logic [31:0] res_freq_reg;
    status_t     res_stat_reg;
    logic        out_valid_reg;
    logic [31:0] out_freq_reg;
    status_t     out_stat_reg;
    logic        oor_reg;

    logic        s_acc;
    logic        in_op;
    logic [6:0]  in_idx;
    logic [31:0] in_ratio;
    logic [7:0]  in_note;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic [7:0]  size_eff;
    logic        out_load;

    logic        mem_wr_en;
    logic        mem_rd_en;
    logic [31:0] mem_rd_data;
    logic [31:0] ratio_rd;

    logic        div_start;
    logic        div_done;
    deg_res_t    div_res;

    logic        pow_start;
    logic        pow_done;
    pow_cmd_t    pow_cmd;
    pow_res_t    pow_res;

    // Field unpacking
    assign in_op    = s_tuser[0];
    assign in_idx   = s_tdata[6:0];
    assign in_ratio = s_tdata[38:7];
    assign in_note  = s_tdata[46:39];

    assign s_tready = (state_reg == T_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // ---------------------------------------------------------------- config port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= BASE_RESET;
            anchor_reg <= ANCHOR_RESET;
            size_reg   <= SIZE_RESET;
            period_reg <= PERIOD_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BASE:   base_reg   <= pwdata;
                REG_ANCHOR: anchor_reg <= pwdata[6:0];
                REG_SIZE:   size_reg   <= pwdata[7:0];
                REG_PERIOD: period_reg <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_BASE:   prdata = base_reg;
            REG_ANCHOR: prdata = {25'd0, anchor_reg};
            REG_SIZE:   prdata = {24'd0, size_reg};
            REG_PERIOD: prdata = period_reg;
        endcase
    end

    // Clamp the cycle length to 1..TABLE_DEPTH
    always_comb begin
        if (size_reg == 8'd0) begin
            size_eff = 8'd1;
        end else if (32'(size_reg) > TABLE_DEPTH) begin
            size_eff = 8'(TABLE_DEPTH);
        end else begin
            size_eff = size_reg;
        end
    end

    // ---------------------------------------------------------------- units
    // Writes beyond the table are dropped but still acknowledged
    assign mem_wr_en = s_acc && (in_op == OP_WRITE) && (32'(in_idx) < MEM_DEPTH);
    assign mem_rd_en = (state_reg == T_DIV) && div_done;
    assign div_start = s_acc && (in_op == OP_QUERY) && !in_note[7];
    assign pow_start = (state_reg == T_READ);

    stnf_ratio_mem #(
        .DEPTH     (MEM_DEPTH),
        .FRAC_BITS (RATIO_FRAC_BITS)
    ) u_mem (
        .clk     (aclk),
        .rst_n   (aresetn),
        .wr_en   (mem_wr_en),
        .wr_addr (in_idx[MEM_AW-1:0]),
        .wr_data (in_ratio),
        .rd_en   (mem_rd_en),
        .rd_addr (div_res.degree[MEM_AW-1:0]),
        .rd_data (mem_rd_data)
    );

    stnf_deg_div u_div (
        .clk    (aclk),
        .rst_n  (aresetn),
        .start  (div_start),
        .note   (in_note[6:0]),
        .anchor (anchor_reg),
        .size   (size_eff),
        .done   (div_done),
        .res    (div_res)
    );

    // Degrees past the storable range read as zero
    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            oor_reg <= (32'(div_res.degree) >= MEM_DEPTH);
        end
    end

    assign ratio_rd = oor_reg ? 32'd0 : mem_rd_data;

    assign pow_cmd.base   = base_reg;
    assign pow_cmd.ratio  = ratio_rd;
    assign pow_cmd.period = period_reg;
    assign pow_cmd.steps  = div_res.steps;
    assign pow_cmd.neg    = div_res.neg;

    stnf_pow_unit #(
        .FRAC_BITS (RATIO_FRAC_BITS)
    ) u_pow (
        .clk   (aclk),
        .rst_n (aresetn),
        .start (pow_start),
        .cmd   (pow_cmd),
        .done  (pow_done),
        .res   (pow_res)
    );

    // ---------------------------------------------------------------- sequencer
    assign out_load = (state_reg == T_DONE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (s_acc) begin
                    state_next = div_start ? T_DIV : T_DONE;
                end
            end
            T_DIV:  if (div_done) state_next = T_READ;
            T_READ: state_next = T_POW;
            T_POW:  if (pow_done) state_next = T_DONE;
            T_DONE: if (out_load) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage the result, then hold it in the output register until taken
    always_ff @(posedge aclk) begin
        if (s_acc && !div_start) begin
            res_freq_reg <= '0;
            res_stat_reg <= (in_op == OP_WRITE) ? ST_WRITE : ST_RANGE;
        end else if ((state_reg == T_POW) && pow_done) begin
            res_freq_reg <= pow_res.freq;
            res_stat_reg <= pow_res.sat ? ST_SAT : ST_OK;
        end
        if (out_load) begin
            out_freq_reg <= res_freq_reg;
            out_stat_reg <= res_stat_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_freq_reg;
    assign m_tuser  = out_stat_reg;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == T_DIV)
        else $error("degree divider finished outside its wait state");

    a_pow_done_in_pow: assert property (@(posedge aclk) disable iff (!aresetn)
        pow_done |-> state_reg == T_POW)
        else $error("power engine finished outside its wait state");

    a_write_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && in_op == OP_WRITE) |=> state_reg == T_DONE && res_stat_reg == ST_WRITE)
        else $error("table write did not stage its acknowledge");

    a_sat_all_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_stat_reg == ST_SAT) |-> out_freq_reg == 32'hFFFF_FFFF)
        else $error("saturated result is not all ones");

    a_zero_on_nonquery: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_stat_reg == ST_WRITE || out_stat_reg == ST_RANGE))
            |-> out_freq_reg == 32'd0)
        else $error("write or range result carries a nonzero frequency");
`endif

endmodule

@@ tb/sv/scale_table_note_to_frequency_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for scale_table_note_to_frequency_top: table writes and note queries
// checked against an in-bench predictor. Depends on stnf_pkg and the block's RTL.
module scale_table_note_to_frequency_top_test;
    import stnf_pkg::*;

    localparam int TABLE_DEPTH    = 128;
    localparam int FRAC           = 28;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SHOWN_ERRORS   = 40;
    localparam int RANDOM_ITEMS   = 1000;

    // One input transaction; hold asks the sender to drain all results before it goes out.
    typedef struct {
        logic        op;
        logic [6:0]  idx;
        logic [31:0] ratio;
        logic [7:0]  note;
        bit          hold;
    } tone_req_t;

    typedef struct {
        logic [31:0] freq;
        status_t     status;
    } freq_result_t;

    // Tracks the tuning registers and the ratio table, and predicts every frequency result.
    class tone_scoreboard;
        bit [31:0]    base_freq;
        bit [6:0]     anchor;
        bit [7:0]     degrees;
        bit [31:0]    period;
        bit [31:0]    ratio_table [TABLE_DEPTH];
        bit [31:0]    et_q30 [12];
        freq_result_t expected_q [$];
        int           errors, n_ok, n_range, n_sat, n_write;

        function new();
            et_q30 = '{32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
                       32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
                       32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652};
            base_freq = 32'd28835840;
            anchor    = 7'd69;
            degrees   = 8'd12;
            period    = 32'h2000_0000;
            for (int k = 0; k < TABLE_DEPTH; k++)
                ratio_table[k] = (k < 12) ? (et_q30[k] >> (30 - FRAC)) : 32'd0;
        endfunction

        function void set_reg(logic [1:0] reg_idx, logic [31:0] value);
            case (reg_idx)
                REG_BASE:   base_freq = value;
                REG_ANCHOR: anchor    = value[6:0];
                REG_SIZE:   degrees   = value[7:0];
                REG_PERIOD: period    = value;
                default:    ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Work out the result of one accepted transaction and queue it.
        function void note_input(tone_req_t t);
            freq_result_t exp_res;
            int           eff, d, q, r, steps;
            bit [63:0]    acc;
            bit           sat;
            exp_res.freq = 32'd0;
            if (t.op == OP_WRITE) begin
                ratio_table[t.idx] = t.ratio;
                exp_res.status = ST_WRITE;
            end else if (t.note >= 8'd128) begin
                exp_res.status = ST_RANGE;
            end else begin
                // Clamp the cycle length to 1..TABLE_DEPTH, then split into degree and cycle.
                eff = (degrees == 0) ? 1 : ((degrees > TABLE_DEPTH) ? TABLE_DEPTH : degrees);
                d = int'(t.note) - int'(anchor);
                q = d / eff;
                r = d % eff;
                if (r < 0) begin
                    r += eff;
                    q -= 1;
                end
                acc = ({32'd0, base_freq} * {32'd0, ratio_table[r]}) >> FRAC;
                sat = (acc > 64'hFFFF_FFFF);
                steps = (q < 0) ? -q : q;
                // Apply the period one step at a time; any overflow saturates.
                for (int i = 0; i < steps && !sat; i++) begin
                    if (q > 0) begin
                        acc = (acc * {32'd0, period}) >> FRAC;
                    end else if (period == 0) begin
                        sat = 1'b1;
                        break;
                    end else begin
                        acc = (acc << FRAC) / {32'd0, period};
                    end
                    if (acc > 64'hFFFF_FFFF) sat = 1'b1;
                end
                exp_res.freq   = sat ? 32'hFFFF_FFFF : acc[31:0];
                exp_res.status = sat ? ST_SAT : ST_OK;
            end
            expected_q.insert(expected_q.size(), exp_res);
        endfunction

        task flag_mismatch(string msg);
            if (errors < SHOWN_ERRORS) $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest prediction.
        task check_result(logic [31:0] freq, logic [1:0] status);
            freq_result_t exp_res;
            if (expected_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result freq=%h status=%0d", freq, status));
                return;
            end
            exp_res = expected_q.pop_front();
            if (status !== exp_res.status)
                flag_mismatch($sformatf("status %0d, want %s", status, exp_res.status.name()));
            if (freq !== exp_res.freq)
                flag_mismatch($sformatf("frequency %h, want %h (%s)", freq, exp_res.freq,
                                        exp_res.status.name()));
            case (exp_res.status)
                ST_OK:    n_ok++;
                ST_RANGE: n_range++;
                ST_SAT:   n_sat++;
                default:  n_write++;
            endcase
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // [6:0] entry_index, [38:7] ratio_value, [46:39] note_number
    logic [0:0]  s_tuser = '0;   // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [31:0] frequency
    logic [1:0]  m_tuser;        // [1:0] status
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tone_scoreboard tone_sb;
    tone_req_t      req_q [$];
    int             queued_items;
    int             config_phases;

    scale_table_note_to_frequency_top #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .RATIO_FRAC_BITS (FRAC)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // Sender: drive queued transactions in bursts of random length separated by random gaps.
    // A held transaction waits until every outstanding result has come back.
    initial begin : tone_sender
        int gap_left, burst_left;
        gap_left   = 0;
        burst_left = 1;
        do @(posedge aclk); while (!aresetn);
        forever begin
            @(posedge aclk);
            if (s_tvalid && s_tready)
                tone_sb.note_input(req_q.pop_front());
            // Hold the current transaction until it is taken.
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (req_q.size() == 0 || (req_q[0].hold && tone_sb.pending() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, req_q[0].note, req_q[0].ratio, req_q[0].idx};
                    s_tuser  <= req_q[0].op;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // Mix long back-to-back stretches with short choppy bursts.
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // Receiver: check accepted results, stall on a rotating ready pattern reloaded now and then.
    initial begin : freq_sink
        bit [15:0] ready_pattern;
        int        reload_left;
        ready_pattern = 16'hFFFF;
        reload_left   = 64;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                tone_sb.check_result(m_tdata, m_tuser);
            if (reload_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'($urandom);
                    2:       ready_pattern = 16'($urandom & $urandom);
                    default: ready_pattern = 16'($urandom | $urandom);
                endcase
                reload_left = $urandom_range(16, 128);
            end else begin
                reload_left--;
            end
            ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
            m_tready <= aresetn ? ready_pattern[0] : 1'b0;
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, tone_sb.pending());
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic queue_tone(logic op, logic [6:0] idx, logic [31:0] ratio, logic [7:0] note,
                              bit hold = 0);
        tone_req_t t;
        t.op    = op;
        t.idx   = idx;
        t.ratio = ratio;
        t.note  = note;
        t.hold  = hold;
        req_q.insert(req_q.size(), t);
        queued_items++;
    endtask

    // Random transaction; writes mostly land inside the active cycle of degrees.
    function automatic tone_req_t random_tone(int degrees);
        tone_req_t t;
        int        eff;
        eff     = (degrees == 0) ? 1 : ((degrees > TABLE_DEPTH) ? TABLE_DEPTH : degrees);
        t.op    = ($urandom_range(0, 4) == 0) ? OP_WRITE : OP_QUERY;
        t.idx   = 7'($urandom_range(0, 127));
        t.ratio = $urandom;
        t.note  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                              : 8'($urandom_range(0, 127));
        t.hold  = 0;
        if (t.op == OP_WRITE) begin
            if ($urandom_range(0, 3) != 0) t.idx = 7'($urandom_range(0, eff - 1));
            case ($urandom_range(0, 7))
                0, 1:    ;
                2:       t.ratio = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
                default: t.ratio = 32'h1000_0000 + ($urandom & 32'h0FFF_FFFF);
            endcase
        end
        return t;
    endfunction

    // Wait until the sender is empty and every predicted result has been checked.
    task automatic wait_idle();
        while (req_q.size() != 0 || s_tvalid || tone_sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tone_sb.set_reg(reg_idx, value);
    endtask

    task automatic configure(logic [31:0] base, logic [6:0] anchor, logic [7:0] size,
                             logic [31:0] period);
        wait_idle();
        apb_write(REG_BASE, base);
        apb_write(REG_ANCHOR, {25'd0, anchor});
        apb_write(REG_SIZE, {24'd0, size});
        apb_write(REG_PERIOD, period);
        config_phases++;
    endtask

    initial begin : stimulus
        logic [31:0] base, period;
        logic [7:0]  size;
        logic [6:0]  anchor;
        int          n_items, hold_at, first_random;
        tone_req_t   t;

        tone_sb = new();
        queued_items  = 0;
        config_phases = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset tuning: anchor, extremes of the note range, out-of-range notes.
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd69);
        queue_tone(OP_QUERY, 7'd127, 32'hFFFF_FFFF, 8'd0);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd127);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd128);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd255);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd57);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd81);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd68);
        // Table writes: full-scale, zero and beyond the active cycle; the in-cycle entries are read back.
        queue_tone(OP_WRITE, 7'd0, 32'hFFFF_FFFF, 8'd255);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd69);
        queue_tone(OP_WRITE, 7'd4, 32'h0, 8'd0);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd73, 1);
        queue_tone(OP_WRITE, 7'd127, 32'h1000_0000, 8'd0);
        queue_tone(OP_WRITE, 7'd11, 32'hFFFF_FFFF, 8'd0);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd116);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd20);

        // Largest base: base times ratio overflows for most degrees.
        configure(32'hFFFF_FFFF, 7'd0, 8'd12, 32'h2000_0000);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd0);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd13);
        for (int i = 0; i < 4; i++)
            queue_tone(OP_QUERY, 7'd0, 32'd0, 8'($urandom_range(0, 127)));

        // Zero base, top anchor, zero cycle length: the longest downward power.
        configure(32'h0, 7'd127, 8'd0, 32'h2000_0000);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd0);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd126);

        // Cycle length beyond the table: every entry is a degree, largest period.
        configure(32'h01B8_0000, 7'd64, 8'd255, 32'hFFFF_FFFF);
        queue_tone(OP_WRITE, 7'd100, 32'h1800_0000, 8'd0);
        queue_tone(OP_WRITE, 7'd127, 32'h1F00_0000, 8'd0);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd63);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd36);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd127);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd0);

        // Zero period: downward steps saturate, upward steps collapse to zero.
        configure(32'h01B8_0000, 7'd60, 8'd1, 32'h0);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd59);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd61);
        queue_tone(OP_QUERY, 7'd0, 32'd0, 8'd60);

        // Random tunings; small cycle lengths make long powers, so keep those phases short.
        first_random = 1;
        while (queued_items < RANDOM_ITEMS + 40) begin
            case ($urandom_range(0, 9))
                0:       base = $urandom;
                1:       base = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
                default: base = ($urandom_range(16, 4000) << 16) | $urandom_range(0, 65535);
            endcase
            anchor = 7'($urandom_range(0, 127));
            case ($urandom_range(0, 9))
                0:       size = 8'($urandom_range(0, 3));
                1:       size = 8'($urandom_range(25, 255));
                default: size = 8'($urandom_range(5, 24));
            endcase
            case ($urandom_range(0, 9))
                0: period = $urandom;
                1: begin
                    case ($urandom_range(0, 3))
                        0:       period = 32'h0;
                        1:       period = 32'h1;
                        2:       period = 32'h1000_0000;
                        default: period = 32'hFFFF_FFFF;
                    endcase
                end
                default: period = 32'h1800_0000 + ($urandom & 32'h0FFF_FFFF);
            endcase
            configure(base, anchor, size, period);
            n_items = (size < 4) ? 5 : $urandom_range(20, 60);
            // Drain all results mid-phase now and then, and always in the first phase.
            hold_at = (first_random || $urandom_range(0, 2) == 0) ? $urandom_range(1, n_items - 1)
                                                                  : -1;
            first_random = 0;
            for (int i = 0; i < n_items; i++) begin
                t = random_tone(size);
                queue_tone(t.op, t.idx, t.ratio, t.note, i == hold_at);
            end
        end

        wait_idle();
        repeat (40) @(posedge aclk);
        $display("covered %0d transactions, %0d tunings: %0d ok, %0d sat, %0d range, %0d writes",
                 queued_items, config_phases + 1, tone_sb.n_ok, tone_sb.n_sat, tone_sb.n_range,
                 tone_sb.n_write);
        $display("mismatches: %0d, results still outstanding: %0d", tone_sb.errors,
                 tone_sb.pending());
        if (tone_sb.errors == 0 && tone_sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
